### sv/fixed_point_biquad_iir_unit_assert.svh
// Assertion macros shared by the biquad filter RTL.
`ifndef FIXED_POINT_BIQUAD_IIR_UNIT_ASSERT_SVH
`define FIXED_POINT_BIQUAD_IIR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FBI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fbi_pkg.sv
// Shared types, constants and arithmetic helpers for the biquad filter.
`timescale 1ns / 1ps
package fbi_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Right shifts applied to each product after rounding.
  localparam int SH_B0 = 24;
  localparam int SH_B1 = 23;
  localparam int SH_B2 = 24;
  localparam int SH_A1 = 14;
  localparam int SH_A2 = 15;

  localparam logic signed [COEF_W-1:0]   RST_B0         = 16'sh76B0;
  localparam logic signed [COEF_W-1:0]   RST_B1         = 16'sh76B0;
  localparam logic signed [COEF_W-1:0]   RST_B2         = 16'sh76B0;
  localparam logic signed [COEF_W-1:0]   RST_A1         = 16'sh74A7;
  localparam logic signed [COEF_W-1:0]   RST_A2         = 16'sh94D7;
  localparam logic signed [SAMPLE_W-1:0] RST_INIT_LAST  = 16'shC000;
  localparam logic signed [SAMPLE_W-1:0] RST_INIT_OLDER = 16'shC000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0         = 3'd0,
    CFG_B1         = 3'd1,
    CFG_B2         = 3'd2,
    CFG_A1         = 3'd3,
    CFG_A2         = 3'd4,
    CFG_INIT_LAST  = 3'd5,
    CFG_INIT_OLDER = 3'd6
  } cfg_idx_t;

  // One classified item as it travels from the front end to the datapath.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
    logic                       emit;
  } cmd_t;

  // Round to nearest (ties upward) and arithmetic shift; keeps the low 16 bits,
  // which is all the wrapped sum needs.
  function automatic logic signed [SAMPLE_W-1:0] rnd_shift(
    input logic signed [PROD_W-1:0] p,
    input int unsigned              sh
  );
    logic signed [PROD_W-1:0] half;
    logic signed [PROD_W-1:0] q;
    half = 32'sd1 <<< (sh - 1);
    q    = (p + half) >>> sh;
    return q[SAMPLE_W-1:0];
  endfunction

endpackage

### sv/fbi_ifs.sv
// Stream interfaces for the sample input and the filtered output.
`timescale 1ns / 1ps
interface fbi_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [fbi_pkg::SAMPLE_W-1:0] sample;
  logic                                prime;
  logic                                restart;

  modport source (output valid, sample, prime, restart, input ready);
  modport sink   (input valid, sample, prime, restart, output ready);
endinterface

interface fbi_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fbi_pkg::SAMPLE_W-1:0] filtered;

  modport source (output valid, filtered, input ready);
  modport sink   (input valid, filtered, output ready);
endinterface

### sv/fbi_front.sv
// Input stage: registers each transaction and classifies it for the datapath.
`timescale 1ns / 1ps
module fbi_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [fbi_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                              in_prime,
  input  logic                              in_restart,
  output logic                              push_valid,
  input  logic                              push_ready,
  output fbi_pkg::cmd_t                     push_cmd
);
  import fbi_pkg::*;
  `include "fixed_point_biquad_iir_unit_assert.svh"

  logic front_v_r, front_v_nxt;
  cmd_t front_cmd_r, front_cmd_nxt;
  logic take;

  assign in_ready   = !front_v_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = front_v_r;
  assign push_cmd   = front_cmd_r;

  always_comb begin
    front_v_nxt   = front_v_r;
    front_cmd_nxt = front_cmd_r;
    if (take) begin
      front_v_nxt           = 1'b1;
      front_cmd_nxt.sample  = in_sample;
      front_cmd_nxt.restart = in_restart;
      front_cmd_nxt.emit    = !in_prime;
    end else if (push_ready) begin
      front_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
    front_cmd_r <= front_cmd_nxt;
  end

  `FBI_ASSERT_NEXT(a_front_hold, front_v_r && !push_ready,
    front_v_r && $stable(front_cmd_r), "front stage lost or changed a stalled item")
  `FBI_ASSERT_NEXT(a_front_take, in_valid && in_ready,
    front_v_r && front_cmd_r.emit == !$past(in_prime), "front stage misclassified an item")

endmodule

### sv/fbi_queue.sv
// Short FIFO that decouples the front end from the datapath.
`timescale 1ns / 1ps
module fbi_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  fbi_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output fbi_pkg::cmd_t pop_cmd
);
  import fbi_pkg::*;
  `include "fixed_point_biquad_iir_unit_assert.svh"

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = cnt_r != FULL_CNT;
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  `FBI_ASSERT_NOW(a_q_bound, 1'b1, cnt_r <= FULL_CNT, "queue count beyond depth")
  `FBI_ASSERT_NEXT(a_q_drain, pop && !push, cnt_r == $past(cnt_r) - 1'b1,
    "queue count did not drop on a pop")

endmodule

### sv/fbi_back.sv
// Datapath: configuration registers, filter history and the output register.
`timescale 1ns / 1ps
module fbi_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fbi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fbi_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  fbi_pkg::cmd_t                       pop_cmd,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fbi_pkg::SAMPLE_W-1:0] out_filtered
);
  import fbi_pkg::*;
  `include "fixed_point_biquad_iir_unit_assert.svh"

  logic signed [COEF_W-1:0]   b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [SAMPLE_W-1:0] init_last_r, init_older_r;
  logic signed [SAMPLE_W-1:0] in_last_r, in_last_nxt, in_older_r, in_older_nxt;
  logic signed [SAMPLE_W-1:0] out_last_r, out_last_nxt, out_older_r, out_older_nxt;
  logic                       out_v_r, out_v_nxt;
  logic signed [SAMPLE_W-1:0] out_data_r, out_data_nxt;

  logic signed [SAMPLE_W-1:0] x, il, io, ol, oo, y;
  logic signed [PROD_W-1:0]   p0, p1, p2, p3, p4;
  logic                       pop;

  assign pop_ready    = !out_v_r || out_ready;
  assign pop          = pop_valid && pop_ready;
  assign out_valid    = out_v_r;
  assign out_filtered = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r         <= RST_B0;
      b1_r         <= RST_B1;
      b2_r         <= RST_B2;
      a1_r         <= RST_A1;
      a2_r         <= RST_A2;
      init_last_r  <= RST_INIT_LAST;
      init_older_r <= RST_INIT_OLDER;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_B0:         b0_r         <= cfg_data;
        CFG_B1:         b1_r         <= cfg_data;
        CFG_B2:         b2_r         <= cfg_data;
        CFG_A1:         a1_r         <= cfg_data;
        CFG_A2:         a2_r         <= cfg_data;
        CFG_INIT_LAST:  init_last_r  <= cfg_data;
        CFG_INIT_OLDER: init_older_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A restart acts on the history before this item is used.
  always_comb begin
    x  = pop_cmd.sample;
    il = pop_cmd.restart ? '0 : in_last_r;
    io = pop_cmd.restart ? '0 : in_older_r;
    ol = pop_cmd.restart ? init_last_r : out_last_r;
    oo = pop_cmd.restart ? init_older_r : out_older_r;
    p0 = b0_r * x;
    p1 = b1_r * il;
    p2 = b2_r * io;
    p3 = a1_r * ol;
    p4 = a2_r * oo;
    y  = rnd_shift(p0, SH_B0) + rnd_shift(p1, SH_B1) + rnd_shift(p2, SH_B2)
       + rnd_shift(p3, SH_A1) + rnd_shift(p4, SH_A2);
  end

  always_comb begin
    in_last_nxt   = in_last_r;
    in_older_nxt  = in_older_r;
    out_last_nxt  = out_last_r;
    out_older_nxt = out_older_r;
    out_v_nxt     = out_v_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (pop) begin
      in_older_nxt  = il;
      in_last_nxt   = x;
      out_last_nxt  = ol;
      out_older_nxt = oo;
      if (pop_cmd.emit) begin
        out_older_nxt = ol;
        out_last_nxt  = y;
        out_v_nxt     = 1'b1;
        out_data_nxt  = y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_last_r   <= '0;
      in_older_r  <= '0;
      out_last_r  <= RST_INIT_LAST;
      out_older_r <= RST_INIT_OLDER;
      out_v_r     <= 1'b0;
    end else begin
      in_last_r   <= in_last_nxt;
      in_older_r  <= in_older_nxt;
      out_last_r  <= out_last_nxt;
      out_older_r <= out_older_nxt;
      out_v_r     <= out_v_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  `FBI_ASSERT_NEXT(a_prime_silent, pop && !pop_cmd.emit, !out_v_r,
    "a priming transaction produced a result")
  `FBI_ASSERT_NEXT(a_emit_result, pop && pop_cmd.emit,
    out_v_r && out_data_r == $past(y) && out_last_r == $past(y),
    "result and output history disagree")

endmodule

### sv/fixed_point_biquad_iir_unit.sv
// Top level of the fixed-point direct-form-I biquad filter.
`timescale 1ns / 1ps
// Sustains one transaction per clock cycle in both directions while the output side does not
// stall. A sample accepted on the input passes the input register, the queue and the output
// register, where its result is held while the output side stalls. The rate is set by the
// combinational recurrence through the five 16x16 multipliers and the adder into the
// registered output history. A priming transaction only updates the input history and gives
// no result; a restart clears the input history and reloads the output history from the
// initial-condition registers. Configuration writes take effect at once and must be made
// while the filter is idle.
module fixed_point_biquad_iir_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fbi_in_if.sink                         in_ch,
  fbi_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [fbi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fbi_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  fbi_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_sample  (in_ch.sample),
    .in_prime   (in_ch.prime),
    .in_restart (in_ch.restart),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  fbi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  fbi_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_cmd      (pop_cmd),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_filtered (out_ch.filtered)
  );

endmodule

### bench/fixed_point_biquad_iir_unit_test.sv
// Self-checking testbench for the fixed-point direct-form-I biquad filter unit.
`timescale 1ns / 1ps
module fixed_point_biquad_iir_unit_test;
  import fbi_pkg::*;

  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int SETTLE_CYCLES   = 8;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DIRECTED_ROWS   = 20;

  localparam logic [CFG_IDX_W-1:0]       CFG_IDX_UNUSED = 3'd7;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
  // Output for a zero sample with cleared input history, reset output history and reset coefficients.
  localparam logic signed [SAMPLE_W-1:0] Y_ZERO_AT_RESET = -16'sd16146;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       prime;
    logic                       restart;
    logic                       known;
    logic signed [SAMPLE_W-1:0] known_filtered;
  } stim_row_t;

  // sample, prime, restart, known, known_filtered
  stim_row_t directed [DIRECTED_ROWS] = '{
    '{16'sh0000, 1'b0, 1'b0, 1'b1, Y_ZERO_AT_RESET},
    '{S_MAX,     1'b0, 1'b0, 1'b0, 16'sh0000},
    '{S_MIN,     1'b0, 1'b0, 1'b0, 16'sh0000},
    '{S_MAX,     1'b0, 1'b0, 1'b0, 16'sh0000},
    '{S_MIN,     1'b0, 1'b0, 1'b0, 16'sh0000},
    '{16'sh3039, 1'b1, 1'b0, 1'b0, 16'sh0000},
    '{16'shFFFF, 1'b1, 1'b0, 1'b0, 16'sh0000},
    '{16'sh0000, 1'b0, 1'b0, 1'b0, 16'sh0000},
    '{16'sh0064, 1'b0, 1'b1, 1'b0, 16'sh0000},
    '{S_MIN,     1'b1, 1'b1, 1'b0, 16'sh0000},
    '{S_MAX,     1'b1, 1'b0, 1'b0, 16'sh0000},
    '{16'sh0001, 1'b0, 1'b0, 1'b0, 16'sh0000},
    '{16'shFFFF, 1'b0, 1'b0, 1'b0, 16'sh0000},
    '{16'sh0000, 1'b0, 1'b1, 1'b1, Y_ZERO_AT_RESET},
    '{16'sh5555, 1'b0, 1'b0, 1'b0, 16'sh0000},
    '{16'shAAAA, 1'b0, 1'b0, 1'b0, 16'sh0000},
    '{S_MIN,     1'b0, 1'b0, 1'b0, 16'sh0000},
    '{S_MIN,     1'b0, 1'b0, 1'b0, 16'sh0000},
    '{S_MAX,     1'b1, 1'b0, 1'b0, 16'sh0000},
    '{S_MAX,     1'b0, 1'b0, 1'b0, 16'sh0000}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fbi_in_if  in_if ();
  fbi_out_if out_if ();

  fixed_point_biquad_iir_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Filter coefficients, restart values and histories as the block should hold them.
  logic signed [SAMPLE_W-1:0] b0_coef, b1_coef, b2_coef, a1_coef, a2_coef;
  logic signed [SAMPLE_W-1:0] init_last, init_older;
  logic signed [SAMPLE_W-1:0] x_prev1, x_prev2, y_prev1, y_prev2;

  logic signed [SAMPLE_W-1:0] filtered_expected [$];
  logic [CFG_DATA_W-1:0]      reg_plan [cfg_idx_t];

  int mismatches;
  int cycle_count;
  int in_idle_pct;
  int out_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               filtered_expected.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Rounded, arithmetically shifted product; only the low 16 bits reach the sum.
  function automatic logic signed [SAMPLE_W-1:0] scaled_term(
    input logic signed [SAMPLE_W-1:0] c,
    input logic signed [SAMPLE_W-1:0] x,
    input int                         sh
  );
    longint p;
    p = (longint'(c) * longint'(x) + (longint'(1) <<< (sh - 1))) >>> sh;
    return p[SAMPLE_W-1:0];
  endfunction

  task automatic reset_filter_model();
    b0_coef    = RST_B0;
    b1_coef    = RST_B1;
    b2_coef    = RST_B2;
    a1_coef    = RST_A1;
    a2_coef    = RST_A2;
    init_last  = RST_INIT_LAST;
    init_older = RST_INIT_OLDER;
    x_prev1    = '0;
    x_prev2    = '0;
    y_prev1    = RST_INIT_LAST;
    y_prev2    = RST_INIT_OLDER;
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_B0:         b0_coef    = data;
      CFG_B1:         b1_coef    = data;
      CFG_B2:         b2_coef    = data;
      CFG_A1:         a1_coef    = data;
      CFG_A2:         a2_coef    = data;
      CFG_INIT_LAST:  init_last  = data;
      CFG_INIT_OLDER: init_older = data;
      default: ;
    endcase
  endtask

  // Advances the filter state for one accepted transaction and queues its output unless it primes.
  task automatic advance_filter(input stim_row_t row);
    logic [SAMPLE_W-1:0]        acc;
    logic signed [SAMPLE_W-1:0] y;
    if (row.restart) begin
      x_prev1 = '0;
      x_prev2 = '0;
      y_prev1 = init_last;
      y_prev2 = init_older;
    end
    if (row.prime) begin
      x_prev2 = x_prev1;
      x_prev1 = row.sample;
    end else begin
      acc = scaled_term(b0_coef, row.sample, SH_B0) + scaled_term(b1_coef, x_prev1, SH_B1)
          + scaled_term(b2_coef, x_prev2, SH_B2) + scaled_term(a1_coef, y_prev1, SH_A1)
          + scaled_term(a2_coef, y_prev2, SH_A2);
      y = acc;
      x_prev2 = x_prev1;
      x_prev1 = row.sample;
      y_prev2 = y_prev1;
      y_prev1 = y;
      filtered_expected.push_back(row.known ? row.known_filtered : y);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input stim_row_t row);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.sample  <= row.sample;
    in_if.prime   <= row.prime;
    in_if.restart <= row.restart;
    do @(posedge clk); while (!in_if.ready);
    advance_filter(row);
    @(negedge clk);
  endtask

  // Priming transactions leave no result, so let the pipeline settle after the last one.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (filtered_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_write(idx, data);
    @(negedge clk);
  endtask

  task automatic program_plan();
    cfg_idx_t idx;
    idx = idx.first();
    do begin
      write_reg(idx, reg_plan[idx]);
      idx = idx.next();
    end while (idx != idx.first());
    // The unused index must leave every register alone.
    write_reg(CFG_IDX_UNUSED, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic plan_phase(input int ph);
    cfg_idx_t idx;
    idx = idx.first();
    do begin
      reg_plan[idx] = CFG_DATA_W'($urandom);
      idx = idx.next();
    end while (idx != idx.first());
    case (ph)
      0: begin
        reg_plan[CFG_B0]         = S_MAX;
        reg_plan[CFG_B1]         = S_MAX;
        reg_plan[CFG_B2]         = S_MAX;
        reg_plan[CFG_A1]         = S_MAX;
        reg_plan[CFG_A2]         = S_MAX;
        reg_plan[CFG_INIT_LAST]  = S_MAX;
        reg_plan[CFG_INIT_OLDER] = S_MIN;
      end
      1: begin
        reg_plan[CFG_B0]         = S_MIN;
        reg_plan[CFG_B1]         = S_MIN;
        reg_plan[CFG_B2]         = S_MIN;
        reg_plan[CFG_A1]         = S_MIN;
        reg_plan[CFG_A2]         = S_MIN;
        reg_plan[CFG_INIT_LAST]  = S_MIN;
        reg_plan[CFG_INIT_OLDER] = S_MAX;
      end
      3: begin
        reg_plan[CFG_B0]         = RST_B0;
        reg_plan[CFG_B1]         = RST_B1;
        reg_plan[CFG_B2]         = RST_B2;
        reg_plan[CFG_A1]         = RST_A1;
        reg_plan[CFG_A2]         = RST_A2;
        reg_plan[CFG_INIT_LAST]  = '0;
        reg_plan[CFG_INIT_OLDER] = '0;
      end
      4: begin
        reg_plan[CFG_B0] = '0;
        reg_plan[CFG_B1] = '0;
        reg_plan[CFG_B2] = '0;
      end
      default: ;
    endcase
  endtask

  function automatic stim_row_t random_row();
    stim_row_t row;
    row = '0;
    case ($urandom_range(0, 19))
      0:       row.sample = S_MAX;
      1:       row.sample = S_MIN;
      2:       row.sample = '0;
      default: row.sample = SAMPLE_W'($urandom);
    endcase
    row.prime   = ($urandom_range(0, 99) < 15);
    row.restart = ($urandom_range(0, 99) < 4);
    return row;
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (filtered_expected.size() == 0) begin
        report_mismatch($sformatf("result %0d with no sample pending", out_if.filtered));
      end else begin
        want = filtered_expected.pop_front();
        if (out_if.filtered !== want)
          report_mismatch($sformatf("filtered %0d, expected %0d", out_if.filtered, want));
      end
    end
  end

  initial begin
    stim_row_t row;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.sample   = '0;
    in_if.prime    = 1'b0;
    in_if.restart  = 1'b0;
    in_idle_pct    = 28;
    out_stall_pct  = 78;
    reset_filter_model();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_item(directed[i]);
    wait_idle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph / 2)
        0: begin
          in_idle_pct   = 28;
          out_stall_pct = 78;
        end
        1: begin
          in_idle_pct   = 78;
          out_stall_pct = 28;
        end
        default: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
      endcase
      plan_phase(ph);
      program_plan();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 2 && n == ITEMS_PER_PHASE / 2) wait_idle();
        // Now and then a fresh start: restart while priming, then a second priming sample.
        if ($urandom_range(0, 99) < 3) begin
          row = random_row();
          row.prime   = 1'b1;
          row.restart = 1'b1;
          send_item(row);
          row = random_row();
          row.prime   = 1'b1;
          row.restart = 1'b0;
          send_item(row);
        end
        send_item(random_row());
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/fbi_pkg.sv
sv/fbi_ifs.sv
sv/fbi_front.sv
sv/fbi_queue.sv
sv/fbi_back.sv
sv/fixed_point_biquad_iir_unit.sv
bench/fixed_point_biquad_iir_unit_test.sv
